@@ sv/mlp_2_2_1_sgd_trainer_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 2-2-1 perceptron trainer
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MLP_2_2_1_SGD_TRAINER_CORE_ASSERT_SVH
`define MLP_2_2_1_SGD_TRAINER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MLPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MLPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mlpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mlpt_pkg
// Shared types, constants and the sigmoid table builder of the trainer.
// ----------------------------------------------------------------------------
package mlpt_pkg;

  localparam int SIG_DEPTH = 256;
  localparam int SIG_LOG2  = $clog2(SIG_DEPTH);
  localparam int WF        = 16;
  localparam int W_W       = 24;
  localparam int DW_W      = 28;
  localparam int MA_W      = 37;
  localparam int MB_W      = 18;
  localparam int P_W       = MA_W + MB_W;
  localparam logic [15:0] LR_RESET = 16'd6554;

  // Weight store slots.
  localparam logic [3:0] W_H1A = 4'd0;
  localparam logic [3:0] W_H1B = 4'd1;
  localparam logic [3:0] W_H1C = 4'd2;
  localparam logic [3:0] W_H2A = 4'd3;
  localparam logic [3:0] W_H2B = 4'd4;
  localparam logic [3:0] W_H2C = 4'd5;
  localparam logic [3:0] W_OA  = 4'd6;
  localparam logic [3:0] W_OB  = 4'd7;
  localparam logic [3:0] W_OC  = 4'd8;
  localparam int         W_NUM = 9;

  typedef logic signed [W_W-1:0] weight_t;
  typedef logic [SIG_DEPTH:0][15:0] sig_tab_t;

  typedef struct packed {
    logic                   clr;
    logic                   we;
    logic [3:0]             addr;
    logic signed [DW_W-1:0] dw;
  } ws_cmd_t;

  localparam weight_t W_RESET [W_NUM] = '{
    24'sd6554, 24'sd13107, 24'sd6554,
    24'sd19661, 24'sd26214, 24'sd13107,
    24'sd32768, 24'sd39322, 24'sd19661
  };

  localparam logic [63:0] E_Q24   = 64'd45605201;
  localparam logic [63:0] ONE_Q24 = 64'd16777216;

  // Rounded-up reciprocals of 1 to 12 in Q36. A series term stays below 2^25,
  // so multiplying by one of these and shifting gives the exact floor quotient.
  localparam int          RECIP_SH = 36;
  localparam logic [63:0] RECIP [12] = '{
    (64'd1 << RECIP_SH),
    ((64'd1 << RECIP_SH) + 64'd1) / 64'd2,
    ((64'd1 << RECIP_SH) + 64'd2) / 64'd3,
    ((64'd1 << RECIP_SH) + 64'd3) / 64'd4,
    ((64'd1 << RECIP_SH) + 64'd4) / 64'd5,
    ((64'd1 << RECIP_SH) + 64'd5) / 64'd6,
    ((64'd1 << RECIP_SH) + 64'd6) / 64'd7,
    ((64'd1 << RECIP_SH) + 64'd7) / 64'd8,
    ((64'd1 << RECIP_SH) + 64'd8) / 64'd9,
    ((64'd1 << RECIP_SH) + 64'd9) / 64'd10,
    ((64'd1 << RECIP_SH) + 64'd10) / 64'd11,
    ((64'd1 << RECIP_SH) + 64'd11) / 64'd12
  };

  // Sigmoid of a Q16 point in [0, 8], via a truncated series for the
  // fraction and repeated multiplication by e for the integer part.
  function automatic logic [15:0] sig_point(input logic [31:0] x);
    logic [63:0] f;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] big;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    int unsigned n;
    f = {48'd0, x[15:0]};
    t = ONE_Q24;
    s = ONE_Q24;
    n = int'(x[31:16]);
    for (int k = 1; k <= 12; k++) begin
      t = (((t * f) >> 16) * RECIP[k-1]) >> RECIP_SH;
      s = s + t;
    end
    for (int k = 0; k < 8; k++) begin
      if (k < n) begin
        s = (s * E_Q24 + 64'd8388608) >> 24;
      end
    end
    big = s + ONE_Q24;
    num = (s << 16) + (big >> 1);
    // Rounded quotient by long division, one bit at a time.
    q   = '0;
    rem = '0;
    for (int j = 63; j >= 0; j--) begin
      rem = {rem[62:0], num[j]};
      if (rem >= big) begin
        rem  = rem - big;
        q[j] = 1'b1;
      end
    end
    return q[15:0];
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t tab;
    logic [63:0] xi;
    for (int i = 0; i <= SIG_DEPTH; i++) begin
      xi     = (64'(i) << 19) >> SIG_LOG2;
      tab[i] = sig_point(xi[31:0]);
    end
    return tab;
  endfunction

endpackage

@@ sv/mlpt_mul.sv @@
// ----------------------------------------------------------------------------
// mlpt_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mlpt_mul (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [mlpt_pkg::MA_W-1:0]  mul_a,
  input  logic signed [mlpt_pkg::MB_W-1:0]  mul_b,
  output logic signed [mlpt_pkg::P_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= mul_a * mul_b;
    end
  end

endmodule

@@ sv/mlpt_wstore.sv @@
// ----------------------------------------------------------------------------
// mlpt_wstore
// Nine-word weight store with a saturating add-update port.
// ----------------------------------------------------------------------------
module mlpt_wstore (
  input  logic              clk,
  input  logic              rst_n,
  input  mlpt_pkg::ws_cmd_t cmd,
  output mlpt_pkg::weight_t rd_data,
  output logic              changed_r
);

  mlpt_pkg::weight_t       w_r [mlpt_pkg::W_NUM];
  mlpt_pkg::weight_t       w_nxt;
  logic signed [mlpt_pkg::DW_W:0] sum;
  logic                    addr_ok;

  assign addr_ok = (cmd.addr < 4'(mlpt_pkg::W_NUM));
  assign rd_data = addr_ok ? w_r[cmd.addr] : '0;

  always_comb begin
    sum = {{(mlpt_pkg::DW_W + 1 - mlpt_pkg::W_W){rd_data[mlpt_pkg::W_W-1]}}, rd_data}
        + {cmd.dw[mlpt_pkg::DW_W-1], cmd.dw};
    if (sum > (mlpt_pkg::DW_W+1)'(8388607)) begin
      w_nxt = 24'sh7FFFFF;
    end else if (sum < -(mlpt_pkg::DW_W+1)'(8388608)) begin
      w_nxt = 24'sh800000;
    end else begin
      w_nxt = sum[mlpt_pkg::W_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mlpt_pkg::W_NUM; i++) begin
        w_r[i] <= mlpt_pkg::W_RESET[i];
      end
      changed_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        changed_r <= 1'b0;
      end else if (cmd.we && addr_ok) begin
        w_r[cmd.addr] <= w_nxt;
        if (w_nxt != rd_data) begin
          changed_r <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/mlpt_ctrl.sv @@
// ----------------------------------------------------------------------------
// mlpt_ctrl
// Sequencer: forward pass, deltas and weight updates on the shared multiplier.
// ----------------------------------------------------------------------------
module mlpt_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_kind,
  input  logic signed [15:0]               in_a,
  input  logic signed [15:0]               in_b,
  input  logic [15:0]                      in_target,
  output logic                             out_valid_r,
  input  logic                             out_ready,
  output logic [15:0]                      pred_r,
  output logic signed [15:0]               delta_r,
  output logic                             chg_r,
  input  logic [15:0]                      lr,
  output mlpt_pkg::ws_cmd_t                cmd,
  input  mlpt_pkg::weight_t                w_rd,
  input  logic                             ws_changed,
  output logic                             mul_en,
  output logic signed [mlpt_pkg::MA_W-1:0] mul_a,
  output logic signed [mlpt_pkg::MB_W-1:0] mul_b,
  input  logic signed [mlpt_pkg::P_W-1:0]  prod
);

  localparam mlpt_pkg::sig_tab_t SigTab = mlpt_pkg::build_sig_tab();
  localparam int AW = mlpt_pkg::MA_W;
  localparam int BW = mlpt_pkg::MB_W;

  typedef enum logic [4:0] {
    S_IDLE, S_H1A, S_H1B, S_H1C, S_H2A, S_H2B, S_H2C, S_OA, S_OB, S_OC,
    S_SIG0, S_SIG1, S_E0, S_E1, S_E2, S_G1A, S_G1B, S_G1C, S_G2A, S_G2B,
    S_G2C, S_L0, S_L1, S_L2, S_L3, S_UPD, S_UPW, S_DONE
  } state_t;

  typedef enum logic [1:0] {SEL_H1, SEL_H2, SEL_Y} sel_t;

  state_t              state_r, state_nxt;
  sel_t                sel_r, sel_nxt;
  logic                kind_r, kind_nxt;
  logic signed [15:0]  a_r, a_nxt, b_r, b_nxt;
  logic [15:0]         t_r, t_nxt;
  logic signed [47:0]  acc_r, acc_nxt;
  logic [15:0]         lo_r, lo_nxt;
  logic                neg_r, neg_nxt;
  logic [15:0]         h1_r, h1_nxt, h2_r, h2_nxt, y_r, y_nxt;
  logic signed [15:0]  e_r, e_nxt;
  logic signed [20:0]  d1_r, d1_nxt, d2_r, d2_nxt;
  logic signed [32:0]  ge_r, ge_nxt;
  logic signed [36:0]  g1h_r, g1h_nxt, g2h_r, g2h_nxt;
  logic [3:0]          wi_r, wi_nxt;
  logic                out_valid_nxt;
  logic [15:0]         pred_nxt;
  logic signed [15:0]  delta_nxt;
  logic                chg_nxt;

  // Sigmoid lookup helpers.
  logic signed [47:0]  net;
  logic [47:0]         mag;
  logic                sat;
  logic [8:0]          idx;
  logic [15:0]         t_lo, t_hi, t_d;
  logic [16:0]         ysum, yfin;
  logic signed [36:0]  upd_src;
  logic signed [17:0]  upd_mul;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    net  = (sel_r == SEL_Y) ? (acc_r >>> mlpt_pkg::WF) : (acc_r >>> (mlpt_pkg::WF - 4));
    mag  = net[47] ? 48'(-net) : 48'(net);
    sat  = (mag >= 48'd524288);
    idx  = {1'b0, mag[18:11]};
    t_lo = sat ? SigTab[mlpt_pkg::SIG_DEPTH] : SigTab[idx];
    t_hi = SigTab[idx + 9'd1];
    t_d  = (t_hi >= t_lo) ? (t_hi - t_lo) : 16'd0;
    ysum = {1'b0, lo_r} + {1'b0, prod[26:11]};
    yfin = neg_r ? (17'h10000 - ysum) : ysum;
  end

  // Operand selection for the weight-update steps.
  always_comb begin
    upd_src = {{4{ge_r[32]}}, ge_r};
    upd_mul = {2'b00, h2_r};
    case (wi_r)
      mlpt_pkg::W_H1A, mlpt_pkg::W_H1B, mlpt_pkg::W_H1C: upd_src = g1h_r;
      mlpt_pkg::W_H2A, mlpt_pkg::W_H2B, mlpt_pkg::W_H2C: upd_src = g2h_r;
      default: upd_src = {{4{ge_r[32]}}, ge_r};
    endcase
    case (wi_r)
      mlpt_pkg::W_H1A, mlpt_pkg::W_H2A: upd_mul = {{2{a_r[15]}}, a_r};
      mlpt_pkg::W_H1B, mlpt_pkg::W_H2B: upd_mul = {{2{b_r[15]}}, b_r};
      mlpt_pkg::W_OA:                   upd_mul = {2'b00, h1_r};
      default:                          upd_mul = {2'b00, h2_r};
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    kind_nxt      = kind_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    t_nxt         = t_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    neg_nxt       = neg_r;
    h1_nxt        = h1_r;
    h2_nxt        = h2_r;
    y_nxt         = y_r;
    e_nxt         = e_r;
    d1_nxt        = d1_r;
    d2_nxt        = d2_r;
    ge_nxt        = ge_r;
    g1h_nxt       = g1h_r;
    g2h_nxt       = g2h_r;
    wi_nxt        = wi_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pred_nxt      = pred_r;
    delta_nxt     = delta_r;
    chg_nxt       = chg_r;
    cmd           = '0;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          a_nxt     = in_a;
          b_nxt     = in_b;
          t_nxt     = in_target;
          e_nxt     = '0;
          cmd.clr   = 1'b1;
          state_nxt = S_H1A;
        end
      end
      S_H1A, S_H2A: begin
        cmd.addr  = (state_r == S_H1A) ? mlpt_pkg::W_H1A : mlpt_pkg::W_H2A;
        mul_en    = 1'b1;
        mul_a     = {{(AW - 24){w_rd[23]}}, w_rd};
        mul_b     = {{2{a_r[15]}}, a_r};
        state_nxt = (state_r == S_H1A) ? S_H1B : S_H2B;
      end
      S_H1B, S_H2B: begin
        cmd.addr  = (state_r == S_H1B) ? mlpt_pkg::W_H1B : mlpt_pkg::W_H2B;
        acc_nxt   = prod[47:0];
        mul_en    = 1'b1;
        mul_a     = {{(AW - 24){w_rd[23]}}, w_rd};
        mul_b     = {{2{b_r[15]}}, b_r};
        state_nxt = (state_r == S_H1B) ? S_H1C : S_H2C;
      end
      S_H1C, S_H2C: begin
        cmd.addr  = (state_r == S_H1C) ? mlpt_pkg::W_H1C : mlpt_pkg::W_H2C;
        acc_nxt   = acc_r + prod[47:0] + ({{24{w_rd[23]}}, w_rd} <<< 12);
        sel_nxt   = (state_r == S_H1C) ? SEL_H1 : SEL_H2;
        state_nxt = S_SIG0;
      end
      S_OA: begin
        cmd.addr  = mlpt_pkg::W_OA;
        mul_en    = 1'b1;
        mul_a     = {{(AW - 24){w_rd[23]}}, w_rd};
        mul_b     = {2'b00, h1_r};
        state_nxt = S_OB;
      end
      S_OB: begin
        cmd.addr  = mlpt_pkg::W_OB;
        acc_nxt   = prod[47:0];
        mul_en    = 1'b1;
        mul_a     = {{(AW - 24){w_rd[23]}}, w_rd};
        mul_b     = {2'b00, h2_r};
        state_nxt = S_OC;
      end
      S_OC: begin
        cmd.addr  = mlpt_pkg::W_OC;
        acc_nxt   = acc_r + prod[47:0] + ({{24{w_rd[23]}}, w_rd} <<< 16);
        sel_nxt   = SEL_Y;
        state_nxt = S_SIG0;
      end
      S_SIG0: begin
        // Beyond the table end the interpolation term is forced to zero.
        lo_nxt    = t_lo;
        neg_nxt   = net[47];
        mul_en    = 1'b1;
        mul_a     = sat ? '0 : {{(AW - 11){1'b0}}, mag[10:0]};
        mul_b     = {2'b00, t_d};
        state_nxt = S_SIG1;
      end
      S_SIG1: begin
        case (sel_r)
          SEL_H1: begin
            h1_nxt    = yfin[16] ? 16'hFFFF : yfin[15:0];
            state_nxt = S_H2A;
          end
          SEL_H2: begin
            h2_nxt    = yfin[16] ? 16'hFFFF : yfin[15:0];
            state_nxt = S_OA;
          end
          default: begin
            y_nxt     = yfin[16] ? 16'hFFFF : yfin[15:0];
            state_nxt = kind_r ? S_DONE : S_E0;
          end
        endcase
      end
      S_E0: begin
        mul_en    = 1'b1;
        mul_a     = {{(AW - 17){1'b0}}, 17'h10000 - {1'b0, y_r}};
        mul_b     = {2'b00, y_r};
        state_nxt = S_E1;
      end
      S_E1: begin
        mul_en    = 1'b1;
        mul_a     = {{(AW - 33){1'b0}}, prod[32:0]};
        mul_b     = {2'b00, t_r} - {2'b00, y_r};
        state_nxt = S_E2;
      end
      S_E2: begin
        e_nxt     = prod[47:32];
        state_nxt = (prod[47:32] == 16'd0) ? S_DONE : S_G1A;
      end
      S_G1A, S_G2A: begin
        if (state_r == S_G2A) begin
          d1_nxt = prod[36:16];
        end
        mul_en    = 1'b1;
        mul_a     = {{(AW - 17){1'b0}},
                     17'h10000 - {1'b0, (state_r == S_G1A) ? h1_r : h2_r}};
        mul_b     = {2'b00, (state_r == S_G1A) ? h1_r : h2_r};
        state_nxt = (state_r == S_G1A) ? S_G1B : S_G2B;
      end
      S_G1B, S_G2B: begin
        cmd.addr  = (state_r == S_G1B) ? mlpt_pkg::W_OA : mlpt_pkg::W_OB;
        mul_en    = 1'b1;
        mul_a     = {{(AW - 24){w_rd[23]}}, w_rd};
        mul_b     = {1'b0, prod[32:16]};
        state_nxt = (state_r == S_G1B) ? S_G1C : S_G2C;
      end
      S_G1C, S_G2C: begin
        mul_en    = 1'b1;
        mul_a     = prod[52:16];
        mul_b     = {{2{e_r[15]}}, e_r};
        state_nxt = (state_r == S_G1C) ? S_G2A : S_L0;
      end
      S_L0: begin
        d2_nxt    = prod[36:16];
        mul_en    = 1'b1;
        mul_a     = {{(AW - 16){1'b0}}, lr};
        mul_b     = {{2{e_r[15]}}, e_r};
        state_nxt = S_L1;
      end
      S_L1: begin
        ge_nxt    = prod[32:0];
        mul_en    = 1'b1;
        mul_a     = {{(AW - 21){d1_r[20]}}, d1_r};
        mul_b     = {2'b00, lr};
        state_nxt = S_L2;
      end
      S_L2: begin
        g1h_nxt   = prod[36:0];
        mul_en    = 1'b1;
        mul_a     = {{(AW - 21){d2_r[20]}}, d2_r};
        mul_b     = {2'b00, lr};
        state_nxt = S_L3;
      end
      S_L3: begin
        g2h_nxt   = prod[36:0];
        wi_nxt    = mlpt_pkg::W_H1A;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.addr = wi_r;
        if (wi_r == mlpt_pkg::W_H1C || wi_r == mlpt_pkg::W_H2C ||
            wi_r == mlpt_pkg::W_OC) begin
          // Bias weights see an input of one, so the step is a plain shift.
          cmd.we = 1'b1;
          cmd.dw = {{(mlpt_pkg::DW_W - 21){upd_src[36]}}, upd_src[36:16]};
          if (wi_r == mlpt_pkg::W_OC) begin
            state_nxt = S_DONE;
          end else begin
            wi_nxt = wi_r + 4'd1;
          end
        end else begin
          mul_en    = 1'b1;
          mul_a     = upd_src;
          mul_b     = upd_mul;
          state_nxt = S_UPW;
        end
      end
      S_UPW: begin
        cmd.addr  = wi_r;
        cmd.we    = 1'b1;
        if (wi_r == mlpt_pkg::W_OA || wi_r == mlpt_pkg::W_OB) begin
          cmd.dw = {{(mlpt_pkg::DW_W - 23){prod[54]}}, prod[54:32]};
        end else begin
          cmd.dw = {prod[54], prod[54:28]};
        end
        wi_nxt    = wi_r + 4'd1;
        state_nxt = S_UPD;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          pred_nxt      = y_r;
          delta_nxt     = e_r;
          chg_nxt       = ws_changed;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sel_r   <= sel_nxt;
    kind_r  <= kind_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    t_r     <= t_nxt;
    acc_r   <= acc_nxt;
    lo_r    <= lo_nxt;
    neg_r   <= neg_nxt;
    h1_r    <= h1_nxt;
    h2_r    <= h2_nxt;
    y_r     <= y_nxt;
    e_r     <= e_nxt;
    d1_r    <= d1_nxt;
    d2_r    <= d2_nxt;
    ge_r    <= ge_nxt;
    g1h_r   <= g1h_nxt;
    g2h_r   <= g2h_nxt;
    wi_r    <= wi_nxt;
    pred_r  <= pred_nxt;
    delta_r <= delta_nxt;
    chg_r   <= chg_nxt;
  end

endmodule

@@ sv/mlp_2_2_1_sgd_trainer_core.sv @@
// ----------------------------------------------------------------------------
// mlp_2_2_1_sgd_trainer_core
// 2-2-1 sigmoid perceptron with in-place backpropagation training.
// ----------------------------------------------------------------------------
// Input beats carry two Q4.12 inputs and a Q0.16 target in in_tdata and the
// kind in in_tuser (0 trains, 1 only infers). Each beat yields exactly one
// result beat with the prediction, the output delta and a flag telling
// whether a stored weight moved.
// The cfg channel writes the Q0.16 learning rate; it is always ready and is
// meant to be written only while no item is in flight.
// All arithmetic runs through one registered multiplier under a sequencer.
// An inference ends after the forward pass; a training step also forms the
// output delta and, unless it is zero, the hidden deltas and weight updates.
// The sequencer returns to idle as the result is registered.
// A new beat is taken only after the previous item has left the sequencer.
// Reset loads the initial weights and the default learning rate.
// If the receiver stalls, the result waits in the output register and the
// next item still runs; its result waits until the register is taken.
// ----------------------------------------------------------------------------
`include "mlp_2_2_1_sgd_trainer_core_assert.svh"

module mlp_2_2_1_sgd_trainer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // in_a [15:0], in_b [31:16], target [47:32]
  input  logic        in_tuser,   // kind [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // prediction [15:0], output_delta [31:16]
  output logic        out_tuser,  // weights_changed [0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]                      lr_r;
  mlpt_pkg::ws_cmd_t                cmd;
  mlpt_pkg::weight_t                w_rd;
  logic                             ws_changed;
  logic                             mul_en;
  logic signed [mlpt_pkg::MA_W-1:0] mul_a;
  logic signed [mlpt_pkg::MB_W-1:0] mul_b;
  logic signed [mlpt_pkg::P_W-1:0]  prod;
  logic [15:0]                      pred;
  logic signed [15:0]               delta;
  logic                             chg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= mlpt_pkg::LR_RESET;
    end else if (cfg_valid) begin
      lr_r <= cfg_data;
    end
  end

  mlpt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_a        (in_tdata[15:0]),
    .in_b        (in_tdata[31:16]),
    .in_target   (in_tdata[47:32]),
    .out_valid_r (out_tvalid),
    .out_ready   (out_tready),
    .pred_r      (pred),
    .delta_r     (delta),
    .chg_r       (chg),
    .lr          (lr_r),
    .cmd         (cmd),
    .w_rd        (w_rd),
    .ws_changed  (ws_changed),
    .mul_en      (mul_en),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .prod        (prod)
  );

  mlpt_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod)
  );

  mlpt_wstore u_wstore (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_data   (w_rd),
    .changed_r (ws_changed)
  );

  assign out_tdata = {delta, pred};
  assign out_tuser = chg;

  `MLPT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "accepted while busy")
  `MLPT_ASSERT_NOW(a_change_needs_delta, out_tvalid && out_tuser, out_tdata[31:16] != 16'd0, "weights changed with zero delta")
  `MLPT_ASSERT_NOW(a_result_after_work, $rose(out_tvalid), !$past(in_tready), "result without a busy period")

endmodule

@@ bench/mlp_2_2_1_sgd_trainer_core_tb.sv @@
// ----------------------------------------------------------------------------
// mlp_2_2_1_sgd_trainer_core_tb
// Self-checking bench for the 2-2-1 perceptron trainer.
// ----------------------------------------------------------------------------
// Drives train and infer beats, keeps its own copy of the weights, the
// learning rate and the sigmoid table, and checks every result beat in order.
// Both stream sides idle in random bursts; the learning rate is swept
// between phases, its extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mlp_2_2_1_sgd_trainer_core_tb;

  localparam logic KIND_TRAIN = 1'b0;
  localparam logic KIND_INFER = 1'b1;
  localparam int   TAB_DEPTH  = 256;
  localparam int   CYCLE_LIMIT = 1000000;
  localparam int   SETTLE_CYCLES = 60;

  typedef struct {
    logic [15:0] prediction;
    logic [15:0] out_delta;
    logic        changed;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  longint         sig_lut [TAB_DEPTH+1];
  longint         weights [9];
  longint         rate;
  result_t        pending_results [$];
  int             failures;
  int             cycles;
  int             n_train;
  int             n_infer;
  int             n_results;
  int             n_moved;
  int             stall_left;
  bit             quiet;

  mlp_2_2_1_sgd_trainer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sigmoid of a Q16 point in [0, 8]: series for the fraction, then one
  // rounded multiply by e per integer unit.
  function automatic longint exp_sigmoid(longint unsigned x);
    longint unsigned frac;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned den;
    int              whole;
    frac  = x & 64'hFFFF;
    whole = int'(x >> 16);
    term  = 64'd16777216;
    sum   = 64'd16777216;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * frac) >> 16) / longint'(k);
      sum  = sum + term;
    end
    for (int k = 0; k < whole; k++) begin
      sum = (sum * 64'd45605201 + 64'd8388608) >> 24;
    end
    den = sum + 64'd16777216;
    return longint'(((sum << 16) + den / 2) / den);
  endfunction

  function automatic longint sigmoid_q16(longint net);
    longint mag;
    longint pos;
    longint idx;
    longint fr;
    longint lo;
    longint hi;
    longint dlt;
    longint y;
    mag = (net < 0) ? -net : net;
    if (mag >= (64'sd8 << 16)) begin
      y = sig_lut[TAB_DEPTH];
    end else begin
      pos = mag * TAB_DEPTH;
      idx = pos >> 19;
      fr  = pos & ((64'sd1 << 19) - 1);
      lo  = sig_lut[idx];
      hi  = sig_lut[idx+1];
      dlt = (hi >= lo) ? hi - lo : 0;
      y   = lo + ((dlt * fr) >> 19);
    end
    if (net < 0) y = 65536 - y;
    if (y > 65535) y = 65535;
    return y;
  endfunction

  function automatic longint sat_weight(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic void reset_network();
    int tenths [9] = '{1, 2, 1, 3, 4, 2, 5, 6, 3};
    for (int i = 0; i <= TAB_DEPTH; i++) begin
      sig_lut[i] = exp_sigmoid((longint'(i) << 19) / TAB_DEPTH);
    end
    for (int i = 0; i < 9; i++) begin
      weights[i] = sat_weight(((longint'(tenths[i]) << 16) + 5) / 10);
    end
    rate = mlpt_pkg::LR_RESET;
  endfunction

  // Forward pass and, for a train step with commit set, the weight update.
  function automatic result_t network_step(logic kind, logic [15:0] ra, logic [15:0] rb,
                                           logic [15:0] rt, bit commit);
    result_t r;
    longint  a;
    longint  b;
    longint  t;
    longint  h1;
    longint  h2;
    longint  y;
    longint  e;
    longint  d1;
    longint  d2;
    longint  ge;
    longint  g1h;
    longint  g2h;
    longint  nw;
    longint  dw [9];
    a  = longint'($signed(ra));
    b  = longint'($signed(rb));
    t  = longint'(rt);
    e  = 0;
    h1 = sigmoid_q16((a * weights[0] + b * weights[1] + weights[2] * 4096) >>> 12);
    h2 = sigmoid_q16((a * weights[3] + b * weights[4] + weights[5] * 4096) >>> 12);
    y  = sigmoid_q16((h1 * weights[6] + h2 * weights[7] + weights[8] * 65536) >>> 16);
    r.changed = 1'b0;
    if (kind == KIND_TRAIN) begin
      e = ((t - y) * (y * (65536 - y))) >>> 32;
      if (e != 0) begin
        d1  = ((((h1 * (65536 - h1)) >> 16) * weights[6] >>> 16) * e) >>> 16;
        d2  = ((((h2 * (65536 - h2)) >> 16) * weights[7] >>> 16) * e) >>> 16;
        ge  = rate * e;
        g1h = rate * d1;
        g2h = rate * d2;
        dw[0] = (g1h * a) >>> 28;
        dw[1] = (g1h * b) >>> 28;
        dw[2] = g1h >>> 16;
        dw[3] = (g2h * a) >>> 28;
        dw[4] = (g2h * b) >>> 28;
        dw[5] = g2h >>> 16;
        dw[6] = (ge * h1) >>> 32;
        dw[7] = (ge * h2) >>> 32;
        dw[8] = ge >>> 16;
        for (int i = 0; i < 9; i++) begin
          nw = sat_weight(weights[i] + dw[i]);
          if (nw != weights[i]) r.changed = 1'b1;
          if (commit) weights[i] = nw;
        end
      end
    end
    r.prediction = y[15:0];
    r.out_delta  = e[15:0];
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_item(logic kind, logic [15:0] a, logic [15:0] b, logic [15:0] t);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {t, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(network_step(kind, a, b, t, 1'b1));
    if (kind == KIND_TRAIN) n_train++;
    else n_infer++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_rate(logic [15:0] value);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    rate = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_item(bit well_formed);
    logic [15:0] a;
    logic [15:0] b;
    if (well_formed) begin
      // Inputs near the usual 0/1 training points keep the network in range.
      a = 16'($signed($urandom_range(0, 8192)) - 16'sd1024);
      b = 16'($signed($urandom_range(0, 8192)) - 16'sd1024);
      send_item(($urandom_range(0, 3) == 0) ? KIND_INFER : KIND_TRAIN, a, b,
                16'($urandom));
    end else begin
      send_item(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_field_extremes();
    logic [15:0] edges [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    for (int i = 0; i < 4; i++) begin
      send_item(KIND_INFER, edges[i], edges[3-i], 16'h0000);
      send_item(KIND_TRAIN, edges[i], edges[i], (i % 2) ? 16'hFFFF : 16'h0000);
    end
    send_item(KIND_INFER, 16'h1000, 16'h0000, 16'hFFFF);
  endtask

  task automatic test_zero_delta();
    result_t peek;
    // A target equal to the prediction leaves the weights untouched.
    peek = network_step(KIND_TRAIN, 16'h1000, 16'h1000, 16'h0000, 1'b0);
    send_item(KIND_TRAIN, 16'h1000, 16'h1000, peek.prediction);
    peek = network_step(KIND_TRAIN, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_item(KIND_TRAIN, 16'h0000, 16'h0000, peek.prediction);
  endtask

  task automatic test_rate_extremes();
    write_rate(16'hFFFF);
    for (int i = 0; i < 6; i++) begin
      send_item(KIND_TRAIN, 16'h7FFF, 16'h8000, 16'hFFFF);
    end
    write_rate(16'h0000);
    send_item(KIND_TRAIN, 16'h1000, 16'h1000, 16'h0000);
    send_item(KIND_INFER, 16'h1000, 16'h1000, 16'h0000);
  endtask

  task automatic test_random_phases();
    logic [15:0] rates [5] = '{mlpt_pkg::LR_RESET, 16'hFFFF, 16'h0000, 16'h0100, 16'h0000};
    rates[4] = 16'($urandom);
    for (int p = 0; p < 5; p++) begin
      write_rate(rates[p]);
      for (int i = 0; i < 300; i++) random_item($urandom_range(0, 9) < 8);
      if (p == 2) drain_results();
    end
  endtask

  task automatic test_quiet_tail();
    write_rate(16'($urandom));
    quiet = 1'b1;
    for (int i = 0; i < 350; i++) random_item($urandom_range(0, 9) < 8);
  endtask

  always @(negedge clk) begin
    if (quiet) begin
      out_tready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result beat tdata=%h tuser=%b", $time, out_tdata,
                 out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (want.changed) n_moved++;
        if (out_tdata[15:0] !== want.prediction) begin
          failures++;
          $display("%0t: prediction expected %h actual %h", $time, want.prediction,
                   out_tdata[15:0]);
        end
        if (out_tdata[31:16] !== want.out_delta) begin
          failures++;
          $display("%0t: output_delta expected %h actual %h", $time, want.out_delta,
                   out_tdata[31:16]);
        end
        if (out_tuser !== want.changed) begin
          failures++;
          $display("%0t: weights_changed expected %b actual %b", $time, want.changed,
                   out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("mlp_2_2_1_sgd_trainer_core: mismatch");
      $finish;
    end
  end

  initial begin
    failures   = 0;
    cycles     = 0;
    n_train    = 0;
    n_infer    = 0;
    n_results  = 0;
    n_moved    = 0;
    stall_left = 0;
    quiet      = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = KIND_TRAIN;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    reset_network();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_field_extremes();
    test_zero_delta();
    test_rate_extremes();
    test_random_phases();
    test_quiet_tail();
    drain_results();
    $display("Covered %0d train and %0d infer beats, %0d results, %0d weight updates,",
             n_train, n_infer, n_results, n_moved);
    $display("across learning rates from zero to full scale with random stalls.");
    if (failures == 0) begin
      $display("mlp_2_2_1_sgd_trainer_core: match");
    end else begin
      $display("mlp_2_2_1_sgd_trainer_core: mismatch");
    end
    $finish;
  end

endmodule
